// File: hdl/cpu8_pkg.sv
package cpu8_pkg;

    typedef logic [5:0] op_t;

    // Operation codes of the decoded item
    localparam op_t OP_ADC   = 6'd0;
    localparam op_t OP_SBC   = 6'd1;
    localparam op_t OP_AND   = 6'd2;
    localparam op_t OP_ORA   = 6'd3;
    localparam op_t OP_EOR   = 6'd4;
    localparam op_t OP_CMP   = 6'd5;
    localparam op_t OP_CPX   = 6'd6;
    localparam op_t OP_CPY   = 6'd7;
    localparam op_t OP_BIT   = 6'd8;
    localparam op_t OP_LDA   = 6'd9;
    localparam op_t OP_LDX   = 6'd10;
    localparam op_t OP_LDY   = 6'd11;
    localparam op_t OP_ASL_A = 6'd12;
    localparam op_t OP_LSR_A = 6'd13;
    localparam op_t OP_ROL_A = 6'd14;
    localparam op_t OP_ROR_A = 6'd15;
    localparam op_t OP_ASL_M = 6'd16;
    localparam op_t OP_LSR_M = 6'd17;
    localparam op_t OP_ROL_M = 6'd18;
    localparam op_t OP_ROR_M = 6'd19;
    localparam op_t OP_INC   = 6'd20;
    localparam op_t OP_DEC   = 6'd21;
    localparam op_t OP_TAX   = 6'd22;
    localparam op_t OP_TXA   = 6'd23;
    localparam op_t OP_DEX   = 6'd24;
    localparam op_t OP_INX   = 6'd25;
    localparam op_t OP_TAY   = 6'd26;
    localparam op_t OP_TYA   = 6'd27;
    localparam op_t OP_DEY   = 6'd28;
    localparam op_t OP_INY   = 6'd29;
    localparam op_t OP_TXS   = 6'd30;
    localparam op_t OP_TSX   = 6'd31;
    localparam op_t OP_CLC   = 6'd32;
    localparam op_t OP_SEC   = 6'd33;
    localparam op_t OP_CLI   = 6'd34;
    localparam op_t OP_SEI   = 6'd35;
    localparam op_t OP_CLV   = 6'd36;
    localparam op_t OP_CLD   = 6'd37;
    localparam op_t OP_SED   = 6'd38;
    localparam op_t OP_STA   = 6'd39;
    localparam op_t OP_STX   = 6'd40;
    localparam op_t OP_STY   = 6'd41;
    localparam op_t OP_PLA   = 6'd42;
    localparam op_t OP_PLP   = 6'd43;
    localparam op_t OP_PHP   = 6'd44;
    localparam op_t OP_BRANCH = 6'd45;
    localparam op_t OP_PHA   = 6'd46;

    // Status bit positions
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [7:0] BREAK_BITS = 8'h30;
    localparam logic [7:0] PULL_MASK  = 8'hCF;

    // Branch flag select (upper two bits of the condition)
    localparam logic [1:0] BR_N = 2'b00;
    localparam logic [1:0] BR_V = 2'b01;
    localparam logic [1:0] BR_C = 2'b10;
    localparam logic [1:0] BR_Z = 2'b11;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] p;
    } arch_t;

    typedef struct packed {
        logic [7:0] wdata;
        logic       wen;
        logic [8:0] saddr;
        logic       sacc;
        logic       taken;
    } result_t;

endpackage

// File: hdl/cpu8_alu.sv
module cpu8_alu (
    input  cpu8_pkg::op_t     op,
    input  logic [7:0]        operand,
    input  logic [2:0]        cond,
    input  cpu8_pkg::arch_t   cur,
    output cpu8_pkg::arch_t   nxt,
    output cpu8_pkg::result_t res
);

    function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
        return {v[7], p[6:2], (v == 8'd0), p[0]};
    endfunction

    logic [7:0] add_m;
    logic [8:0] sum;
    logic       add_v;
    logic [7:0] cmp_src;
    logic [8:0] diff;
    logic [7:0] sh_src;
    logic [7:0] sh_res;
    logic       sh_c;
    logic       br_flag;
    logic [7:0] sp_inc;
    logic [7:0] sp_dec;
    logic [7:0] php_p;
    logic [7:0] tmp;

    // Binary adder shared by ADC and SBC (SBC adds the inverted operand)
    assign add_m = (op == cpu8_pkg::OP_SBC) ? ~operand : operand;
    assign sum   = {1'b0, cur.acc} + {1'b0, add_m} + {8'd0, cur.p[cpu8_pkg::FLAG_C]};
    assign add_v = (cur.acc[7] ^ sum[7]) & (add_m[7] ^ sum[7]);

    // Compare: carry out of reg + ~m + 1 is reg >= m
    always_comb
    begin
        case (op)
            cpu8_pkg::OP_CPX: cmp_src = cur.x;
            cpu8_pkg::OP_CPY: cmp_src = cur.y;
            default:          cmp_src = cur.acc;
        endcase
    end
    assign diff = {1'b0, cmp_src} + {1'b0, ~operand} + 9'd1;

    // Shifter: kind from the low two code bits (ASL, LSR, ROL, ROR)
    assign sh_src = (op < cpu8_pkg::OP_ASL_M) ? cur.acc : operand;
    always_comb
    begin
        case (op[1:0])
            2'b00:
            begin
                sh_res = {sh_src[6:0], 1'b0};
                sh_c   = sh_src[7];
            end
            2'b01:
            begin
                sh_res = {1'b0, sh_src[7:1]};
                sh_c   = sh_src[0];
            end
            2'b10:
            begin
                sh_res = {sh_src[6:0], cur.p[cpu8_pkg::FLAG_C]};
                sh_c   = sh_src[7];
            end
            default:
            begin
                sh_res = {cur.p[cpu8_pkg::FLAG_C], sh_src[7:1]};
                sh_c   = sh_src[0];
            end
        endcase
    end

    always_comb
    begin
        case (cond[2:1])
            cpu8_pkg::BR_N: br_flag = cur.p[cpu8_pkg::FLAG_N];
            cpu8_pkg::BR_V: br_flag = cur.p[cpu8_pkg::FLAG_V];
            cpu8_pkg::BR_C: br_flag = cur.p[cpu8_pkg::FLAG_C];
            default:        br_flag = cur.p[cpu8_pkg::FLAG_Z];
        endcase
    end

    assign sp_inc = cur.sp + 8'd1;
    assign sp_dec = cur.sp - 8'd1;
    assign php_p  = cur.p | cpu8_pkg::BREAK_BITS;

    always_comb
    begin
        nxt       = cur;
        res.wdata = 8'd0;
        res.wen   = 1'b0;
        res.sacc  = 1'b0;
        res.taken = 1'b0;
        tmp       = 8'd0;
        case (op)
            cpu8_pkg::OP_ADC, cpu8_pkg::OP_SBC:
            begin
                nxt.acc = sum[7:0];
                nxt.p   = with_nz(cur.p, sum[7:0]);
                nxt.p[cpu8_pkg::FLAG_C] = sum[8];
                nxt.p[cpu8_pkg::FLAG_V] = add_v;
            end
            cpu8_pkg::OP_AND:
            begin
                nxt.acc = cur.acc & operand;
                nxt.p   = with_nz(cur.p, nxt.acc);
            end
            cpu8_pkg::OP_ORA:
            begin
                nxt.acc = cur.acc | operand;
                nxt.p   = with_nz(cur.p, nxt.acc);
            end
            cpu8_pkg::OP_EOR:
            begin
                nxt.acc = cur.acc ^ operand;
                nxt.p   = with_nz(cur.p, nxt.acc);
            end
            cpu8_pkg::OP_CMP, cpu8_pkg::OP_CPX, cpu8_pkg::OP_CPY:
            begin
                nxt.p = with_nz(cur.p, diff[7:0]);
                nxt.p[cpu8_pkg::FLAG_C] = diff[8];
            end
            cpu8_pkg::OP_BIT:
            begin
                nxt.p[cpu8_pkg::FLAG_Z] = ((cur.acc & operand) == 8'd0);
                nxt.p[cpu8_pkg::FLAG_V] = operand[6];
                nxt.p[cpu8_pkg::FLAG_N] = operand[7];
            end
            cpu8_pkg::OP_LDA:
            begin
                nxt.acc = operand;
                nxt.p   = with_nz(cur.p, operand);
            end
            cpu8_pkg::OP_LDX:
            begin
                nxt.x = operand;
                nxt.p = with_nz(cur.p, operand);
            end
            cpu8_pkg::OP_LDY:
            begin
                nxt.y = operand;
                nxt.p = with_nz(cur.p, operand);
            end
            cpu8_pkg::OP_ASL_A, cpu8_pkg::OP_LSR_A,
            cpu8_pkg::OP_ROL_A, cpu8_pkg::OP_ROR_A:
            begin
                nxt.acc = sh_res;
                nxt.p   = with_nz(cur.p, sh_res);
                nxt.p[cpu8_pkg::FLAG_C] = sh_c;
            end
            cpu8_pkg::OP_ASL_M, cpu8_pkg::OP_LSR_M,
            cpu8_pkg::OP_ROL_M, cpu8_pkg::OP_ROR_M:
            begin
                res.wdata = sh_res;
                res.wen   = 1'b1;
                nxt.p     = with_nz(cur.p, sh_res);
                nxt.p[cpu8_pkg::FLAG_C] = sh_c;
            end
            cpu8_pkg::OP_INC, cpu8_pkg::OP_DEC:
            begin
                tmp       = (op == cpu8_pkg::OP_INC) ? operand + 8'd1 : operand - 8'd1;
                res.wdata = tmp;
                res.wen   = 1'b1;
                nxt.p     = with_nz(cur.p, tmp);
            end
            cpu8_pkg::OP_TAX:
            begin
                nxt.x = cur.acc;
                nxt.p = with_nz(cur.p, cur.acc);
            end
            cpu8_pkg::OP_TXA:
            begin
                nxt.acc = cur.x;
                nxt.p   = with_nz(cur.p, cur.x);
            end
            cpu8_pkg::OP_DEX, cpu8_pkg::OP_INX:
            begin
                nxt.x = (op == cpu8_pkg::OP_INX) ? cur.x + 8'd1 : cur.x - 8'd1;
                nxt.p = with_nz(cur.p, nxt.x);
            end
            cpu8_pkg::OP_TAY:
            begin
                nxt.y = cur.acc;
                nxt.p = with_nz(cur.p, cur.acc);
            end
            cpu8_pkg::OP_TYA:
            begin
                nxt.acc = cur.y;
                nxt.p   = with_nz(cur.p, cur.y);
            end
            cpu8_pkg::OP_DEY, cpu8_pkg::OP_INY:
            begin
                nxt.y = (op == cpu8_pkg::OP_INY) ? cur.y + 8'd1 : cur.y - 8'd1;
                nxt.p = with_nz(cur.p, nxt.y);
            end
            cpu8_pkg::OP_TXS: nxt.sp = cur.x;
            cpu8_pkg::OP_TSX:
            begin
                nxt.x = cur.sp;
                nxt.p = with_nz(cur.p, cur.sp);
            end
            cpu8_pkg::OP_CLC: nxt.p[cpu8_pkg::FLAG_C] = 1'b0;
            cpu8_pkg::OP_SEC: nxt.p[cpu8_pkg::FLAG_C] = 1'b1;
            cpu8_pkg::OP_CLI: nxt.p[cpu8_pkg::FLAG_I] = 1'b0;
            cpu8_pkg::OP_SEI: nxt.p[cpu8_pkg::FLAG_I] = 1'b1;
            cpu8_pkg::OP_CLV: nxt.p[cpu8_pkg::FLAG_V] = 1'b0;
            cpu8_pkg::OP_CLD: nxt.p[cpu8_pkg::FLAG_D] = 1'b0;
            cpu8_pkg::OP_SED: nxt.p[cpu8_pkg::FLAG_D] = 1'b1;
            cpu8_pkg::OP_STA:
            begin
                res.wdata = cur.acc;
                res.wen   = 1'b1;
            end
            cpu8_pkg::OP_STX:
            begin
                res.wdata = cur.x;
                res.wen   = 1'b1;
            end
            cpu8_pkg::OP_STY:
            begin
                res.wdata = cur.y;
                res.wen   = 1'b1;
            end
            cpu8_pkg::OP_PLA:
            begin
                nxt.sp   = sp_inc;
                res.sacc = 1'b1;
                nxt.acc  = operand;
                nxt.p    = with_nz(cur.p, operand);
            end
            cpu8_pkg::OP_PLP:
            begin
                nxt.sp   = sp_inc;
                res.sacc = 1'b1;
                nxt.p    = operand & cpu8_pkg::PULL_MASK;
            end
            cpu8_pkg::OP_PHP:
            begin
                nxt.p     = php_p;
                res.wdata = php_p;
                res.wen   = 1'b1;
                res.sacc  = 1'b1;
                nxt.sp    = sp_dec;
            end
            cpu8_pkg::OP_BRANCH: res.taken = (br_flag == cond[0]);
            cpu8_pkg::OP_PHA:
            begin
                res.wdata = cur.acc;
                res.wen   = 1'b1;
                res.sacc  = 1'b1;
                nxt.sp    = sp_dec;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
        // Pushes address the old stack pointer; everything else shows the new one
        res.saddr = {1'b1, (res.sacc && res.wen) ? cur.sp : nxt.sp};
    end

endmodule

// File: hdl/cpu8_regs.sv
module cpu8_regs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            commit,
    input  cpu8_pkg::arch_t arch_next,
    output cpu8_pkg::arch_t arch
);

    cpu8_pkg::arch_t arch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arch_reg <= '0;
        end
        else if (commit)
        begin
            arch_reg <= arch_next;
        end
    end

    assign arch = arch_reg;

endmodule

// File: hdl/cpu8_execute_unit.sv
// Channel | Handshake              | Payload
// in      | in_valid / in_ready    | operation, operand, branch_condition
// out     | out_valid / out_ready  | write_data, write_enable, stack_address, stack_access,
//         |                        | branch_taken, status_value, acc_value, x_value,
//         |                        | y_value, sp_value
//
// One item per cycle sustained while out_ready stays high; each item passes
// through the input register, then the ALU into the result register.
// A, X, Y, SP and P update in the cycle an item moves into the result register,
// so the next item in the input register always sees the updated state.
// The register values on the out channel come straight from the register file,
// which only changes when a new result is loaded.
// Reset (rst_n low, async) clears A, X, Y, SP and P to zero and both stages to empty.
// A stalled result holds its stage; the input register still takes one more item.
module cpu8_execute_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [5:0] operation,
    input  logic [7:0] operand,
    input  logic [2:0] branch_condition,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] write_data,
    output logic       write_enable,
    output logic [8:0] stack_address,
    output logic       stack_access,
    output logic       branch_taken,
    output logic [7:0] status_value,
    output logic [7:0] acc_value,
    output logic [7:0] x_value,
    output logic [7:0] y_value,
    output logic [7:0] sp_value
);

    // Input stage
    logic              in_vld_reg;
    logic              in_vld_next;
    cpu8_pkg::op_t     op_reg;
    logic [7:0]        operand_reg;
    logic [2:0]        cond_reg;

    // Result stage
    logic              out_vld_reg;
    logic              out_vld_next;
    cpu8_pkg::result_t res_reg;

    cpu8_pkg::arch_t   arch;
    cpu8_pkg::arch_t   arch_nxt;
    cpu8_pkg::result_t res;
    logic              advance;
    logic              in_take;

    // Item leaves the input stage when the result register is free or draining
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;
    assign in_take  = in_valid && in_ready;

    assign in_vld_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    assign out_vld_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg      <= operation;
            operand_reg <= operand;
            cond_reg    <= branch_condition;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    cpu8_alu u_alu (
        .op      (op_reg),
        .operand (operand_reg),
        .cond    (cond_reg),
        .cur     (arch),
        .nxt     (arch_nxt),
        .res     (res)
    );

    cpu8_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .commit    (advance),
        .arch_next (arch_nxt),
        .arch      (arch)
    );

    assign out_valid     = out_vld_reg;
    assign write_data    = res_reg.wdata;
    assign write_enable  = res_reg.wen;
    assign stack_address = res_reg.saddr;
    assign stack_access  = res_reg.sacc;
    assign branch_taken  = res_reg.taken;
    assign status_value  = arch.p;
    assign acc_value     = arch.acc;
    assign x_value       = arch.x;
    assign y_value       = arch.y;
    assign sp_value      = arch.sp;

`ifndef ASSERT_OFF
    // A push leaves SP one below the slot it wrote
    a_push_sp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stack_access && write_enable)
            |-> (sp_value == (stack_address[7:0] - 8'd1)))
        else $error("push: SP does not follow stack address");

    // A pop leaves SP on the slot it read
    a_pop_sp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stack_access && !write_enable)
            |-> (sp_value == stack_address[7:0]))
        else $error("pop: SP does not match stack address");

    // Stack address always lies in page one
    a_page_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> stack_address[8])
        else $error("stack address outside page one");

    // A taken branch never writes or touches the stack
    a_branch_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && branch_taken) |-> (!write_enable && !stack_access))
        else $error("taken branch with side effects");

    // Register state must not move while a result is stalled
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready)
            |=> ($stable(acc_value) && $stable(x_value) && $stable(y_value)
                 && $stable(sp_value) && $stable(status_value)))
        else $error("registers changed under a stalled result");
`endif

endmodule

// File: test/cpu8_execute_unit_test.sv
`timescale 1ns / 100ps

module cpu8_execute_unit_test;

    // One decoded operation waiting to be issued. A barrier item is held back
    // until every earlier item has retired.
    typedef struct {
        cpu8_pkg::op_t op;
        logic [7:0]    operand;
        logic [2:0]    cond;
        bit            barrier;
    } instr_t;

    // What one operation must retire with: side effects plus the register file
    typedef struct packed {
        cpu8_pkg::result_t side;
        cpu8_pkg::arch_t   regs;
    } retire_t;

    // Shift/rotate kind, taken from the low two bits of the operation code
    localparam logic [1:0] SH_ASL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ROL = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    // Receiver stall modes
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_EVERY4, RX_STARVE} rx_mode_t;

    localparam int NUM_RANDOM = 1750;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [5:0] operation = '0;
    logic [7:0] operand = '0;
    logic [2:0] branch_condition = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] write_data;
    logic       write_enable;
    logic [8:0] stack_address;
    logic       stack_access;
    logic       branch_taken;
    logic [7:0] status_value;
    logic [7:0] acc_value;
    logic [7:0] x_value;
    logic [7:0] y_value;
    logic [7:0] sp_value;

    instr_t          instr_q[$];   // filled up front, drained by the issue side
    retire_t         retire_q[$];  // predicted retirements, oldest first
    cpu8_pkg::arch_t cpu_state;    // shadow register file, all zero after reset
    logic            all_retired = 1'b1;
    int              errors = 0;

    // issue side pacing
    int       burst_left = 0;
    int       gap_left = 0;

    // receive side pacing
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_phase = 0;

    cpu8_execute_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .operand          (operand),
        .branch_condition (branch_condition),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .write_data       (write_data),
        .write_enable     (write_enable),
        .stack_address    (stack_address),
        .stack_access     (stack_access),
        .branch_taken     (branch_taken),
        .status_value     (status_value),
        .acc_value        (acc_value),
        .x_value          (x_value),
        .y_value          (y_value),
        .sp_value         (sp_value)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Executes one operation on the shadow register file and returns what the
    // block must retire for it.
    function automatic retire_t execute_op(cpu8_pkg::op_t op, logic [7:0] m, logic [2:0] cond);
        retire_t         r;
        cpu8_pkg::arch_t st;
        logic [7:0]      addend;
        logic [8:0]      sum;
        logic [7:0]      v;
        logic [7:0]      res;
        logic            carry;
        logic            nz_upd;
        logic [7:0]      nz_val;
        logic            flag;
        st = cpu_state;
        r = '0;
        nz_upd = 1'b0;
        nz_val = 8'h00;
        case (op)
            cpu8_pkg::OP_ADC, cpu8_pkg::OP_SBC:
            begin
                // SBC is ADC of the inverted operand; decimal flag is ignored
                addend = (op == cpu8_pkg::OP_SBC) ? ~m : m;
                sum = st.acc + addend + st.p[cpu8_pkg::FLAG_C];
                res = sum[7:0];
                st.p[cpu8_pkg::FLAG_C] = sum[8];
                st.p[cpu8_pkg::FLAG_V] = (st.acc[7] ^ res[7]) & (addend[7] ^ res[7]);
                st.acc = res;
                nz_upd = 1'b1;
                nz_val = res;
            end
            cpu8_pkg::OP_AND, cpu8_pkg::OP_ORA, cpu8_pkg::OP_EOR:
            begin
                if (op == cpu8_pkg::OP_AND)
                    st.acc = st.acc & m;
                else if (op == cpu8_pkg::OP_ORA)
                    st.acc = st.acc | m;
                else
                    st.acc = st.acc ^ m;
                nz_upd = 1'b1;
                nz_val = st.acc;
            end
            cpu8_pkg::OP_CMP, cpu8_pkg::OP_CPX, cpu8_pkg::OP_CPY:
            begin
                v = (op == cpu8_pkg::OP_CMP) ? st.acc : (op == cpu8_pkg::OP_CPX) ? st.x : st.y;
                st.p[cpu8_pkg::FLAG_C] = (v >= m);
                nz_upd = 1'b1;
                nz_val = v - m;
            end
            cpu8_pkg::OP_BIT:
            begin
                st.p[cpu8_pkg::FLAG_Z] = ((st.acc & m) == 8'h00);
                st.p[cpu8_pkg::FLAG_V] = m[6];
                st.p[cpu8_pkg::FLAG_N] = m[7];
            end
            cpu8_pkg::OP_LDA, cpu8_pkg::OP_LDX, cpu8_pkg::OP_LDY:
            begin
                if (op == cpu8_pkg::OP_LDA)
                    st.acc = m;
                else if (op == cpu8_pkg::OP_LDX)
                    st.x = m;
                else
                    st.y = m;
                nz_upd = 1'b1;
                nz_val = m;
            end
            cpu8_pkg::OP_ASL_A, cpu8_pkg::OP_LSR_A, cpu8_pkg::OP_ROL_A, cpu8_pkg::OP_ROR_A,
            cpu8_pkg::OP_ASL_M, cpu8_pkg::OP_LSR_M, cpu8_pkg::OP_ROL_M, cpu8_pkg::OP_ROR_M:
            begin
                v = (op < cpu8_pkg::OP_ASL_M) ? st.acc : m;
                case (op[1:0])
                    SH_ASL: {carry, res} = {v, 1'b0};
                    SH_LSR: {res, carry} = {1'b0, v};
                    SH_ROL: {carry, res} = {v, st.p[cpu8_pkg::FLAG_C]};
                    default: {res, carry} = {st.p[cpu8_pkg::FLAG_C], v};
                endcase
                st.p[cpu8_pkg::FLAG_C] = carry;
                nz_upd = 1'b1;
                nz_val = res;
                if (op < cpu8_pkg::OP_ASL_M)
                    st.acc = res;
                else
                begin
                    r.side.wdata = res;
                    r.side.wen = 1'b1;
                end
            end
            cpu8_pkg::OP_INC, cpu8_pkg::OP_DEC:
            begin
                res = (op == cpu8_pkg::OP_INC) ? m + 8'd1 : m - 8'd1;
                nz_upd = 1'b1;
                nz_val = res;
                r.side.wdata = res;
                r.side.wen = 1'b1;
            end
            cpu8_pkg::OP_TAX: begin st.x = st.acc; nz_upd = 1'b1; nz_val = st.x; end
            cpu8_pkg::OP_TXA: begin st.acc = st.x; nz_upd = 1'b1; nz_val = st.acc; end
            cpu8_pkg::OP_DEX: begin st.x = st.x - 8'd1; nz_upd = 1'b1; nz_val = st.x; end
            cpu8_pkg::OP_INX: begin st.x = st.x + 8'd1; nz_upd = 1'b1; nz_val = st.x; end
            cpu8_pkg::OP_TAY: begin st.y = st.acc; nz_upd = 1'b1; nz_val = st.y; end
            cpu8_pkg::OP_TYA: begin st.acc = st.y; nz_upd = 1'b1; nz_val = st.acc; end
            cpu8_pkg::OP_DEY: begin st.y = st.y - 8'd1; nz_upd = 1'b1; nz_val = st.y; end
            cpu8_pkg::OP_INY: begin st.y = st.y + 8'd1; nz_upd = 1'b1; nz_val = st.y; end
            cpu8_pkg::OP_TXS: st.sp = st.x;
            cpu8_pkg::OP_TSX: begin st.x = st.sp; nz_upd = 1'b1; nz_val = st.x; end
            cpu8_pkg::OP_CLC: st.p[cpu8_pkg::FLAG_C] = 1'b0;
            cpu8_pkg::OP_SEC: st.p[cpu8_pkg::FLAG_C] = 1'b1;
            cpu8_pkg::OP_CLI: st.p[cpu8_pkg::FLAG_I] = 1'b0;
            cpu8_pkg::OP_SEI: st.p[cpu8_pkg::FLAG_I] = 1'b1;
            cpu8_pkg::OP_CLV: st.p[cpu8_pkg::FLAG_V] = 1'b0;
            cpu8_pkg::OP_CLD: st.p[cpu8_pkg::FLAG_D] = 1'b0;
            cpu8_pkg::OP_SED: st.p[cpu8_pkg::FLAG_D] = 1'b1;
            cpu8_pkg::OP_STA, cpu8_pkg::OP_STX, cpu8_pkg::OP_STY:
            begin
                r.side.wdata = (op == cpu8_pkg::OP_STA) ? st.acc
                             : (op == cpu8_pkg::OP_STX) ? st.x : st.y;
                r.side.wen = 1'b1;
            end
            cpu8_pkg::OP_PLA, cpu8_pkg::OP_PLP:
            begin
                // pop: pre-increment, then read page one at the new SP
                st.sp = st.sp + 8'd1;
                r.side.saddr = {1'b1, st.sp};
                r.side.sacc = 1'b1;
                if (op == cpu8_pkg::OP_PLA)
                begin
                    st.acc = m;
                    nz_upd = 1'b1;
                    nz_val = m;
                end
                else
                    st.p = m & cpu8_pkg::PULL_MASK;
            end
            cpu8_pkg::OP_PHP, cpu8_pkg::OP_PHA:
            begin
                // push: write at SP, then post-decrement; PHP sets B in P itself
                if (op == cpu8_pkg::OP_PHP)
                    st.p = st.p | cpu8_pkg::BREAK_BITS;
                r.side.wdata = (op == cpu8_pkg::OP_PHP) ? st.p : st.acc;
                r.side.wen = 1'b1;
                r.side.saddr = {1'b1, st.sp};
                r.side.sacc = 1'b1;
                st.sp = st.sp - 8'd1;
            end
            cpu8_pkg::OP_BRANCH:
            begin
                case (cond[2:1])
                    cpu8_pkg::BR_N: flag = st.p[cpu8_pkg::FLAG_N];
                    cpu8_pkg::BR_V: flag = st.p[cpu8_pkg::FLAG_V];
                    cpu8_pkg::BR_C: flag = st.p[cpu8_pkg::FLAG_C];
                    default: flag = st.p[cpu8_pkg::FLAG_Z];
                endcase
                r.side.taken = cond[0] ? flag : ~flag;
            end
            default: ;  // unused codes leave everything alone
        endcase
        if (nz_upd)
        begin
            st.p[cpu8_pkg::FLAG_Z] = (nz_val == 8'h00);
            st.p[cpu8_pkg::FLAG_N] = nz_val[7];
        end
        // no stack access: the address just reflects the current SP
        if (!r.side.sacc)
            r.side.saddr = {1'b1, st.sp};
        r.regs = st;
        cpu_state = st;
        return r;
    endfunction

    function automatic void check_field(string name, logic [8:0] want, logic [8:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic queue_instr(cpu8_pkg::op_t op, logic [7:0] m, logic [2:0] cond, bit barrier);
        instr_t it;
        it.op = op;
        it.operand = m;
        it.cond = cond;
        it.barrier = barrier;
        instr_q.push_back(it);
    endtask

    // Issue side: bursts of random length separated by random gaps. Valid is
    // only ever changed when the bus is free, so a pending item never drops.
    always @(posedge clk)
    begin : driver
        logic send;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                void'(instr_q.pop_front());
            send = 1'b0;
            if (in_valid && !in_ready)
                send = 1'b1;
            else if (instr_q.size() == 0)
                send = 1'b0;
            else if (instr_q[0].barrier && (in_valid || !all_retired))
                send = 1'b0;  // let the pipe empty out first
            else if (gap_left > 0)
                gap_left--;
            else
            begin
                send = 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    // mostly short bursts, now and then a long unbroken run
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                             : $urandom_range(1, 8);
                    gap_left = $urandom_range(1, 6);
                end
            end
            in_valid <= send;
            if (send)
            begin
                operation <= instr_q[0].op;
                operand <= instr_q[0].operand;
                branch_condition <= instr_q[0].cond;
            end
        end
    end

    // Receive side: stall pattern switches between modes every so often
    always @(posedge clk)
    begin : receiver
        if (rst_n)
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            rx_phase++;
            case (rx_mode)
                RX_OPEN: out_ready <= 1'b1;
                RX_COIN: out_ready <= 1'($urandom_range(0, 1));
                RX_EVERY4: out_ready <= (rx_phase % 4 == 0);
                default: out_ready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // Predict on every accepted item, check on every accepted result
    always @(posedge clk)
    begin : monitor
        retire_t exp_r;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                retire_q.push_back(execute_op(operation, operand, branch_condition));
            if (out_valid && out_ready)
            begin
                if (retire_q.size() == 0)
                begin
                    $display("%0t: result with no item outstanding", $time);
                    errors++;
                end
                else
                begin
                    exp_r = retire_q.pop_front();
                    check_field("write_data", 9'(exp_r.side.wdata), 9'(write_data));
                    check_field("write_enable", 9'(exp_r.side.wen), 9'(write_enable));
                    check_field("stack_address", exp_r.side.saddr, stack_address);
                    check_field("stack_access", 9'(exp_r.side.sacc), 9'(stack_access));
                    check_field("branch_taken", 9'(exp_r.side.taken), 9'(branch_taken));
                    check_field("status_value", 9'(exp_r.regs.p), 9'(status_value));
                    check_field("acc_value", 9'(exp_r.regs.acc), 9'(acc_value));
                    check_field("x_value", 9'(exp_r.regs.x), 9'(x_value));
                    check_field("y_value", 9'(exp_r.regs.y), 9'(y_value));
                    check_field("sp_value", 9'(exp_r.regs.sp), 9'(sp_value));
                end
            end
            all_retired <= (retire_q.size() == 0);
        end
    end

    initial
    begin : stimulus
        int            n;
        cpu8_pkg::op_t op;
        logic [7:0]    m;
        cpu_state = '0;

        // Directed: stack wrap both ways, arithmetic corners, flag ops
        queue_instr(cpu8_pkg::OP_PHA, 8'h00, 3'd0, 1'b0);     // push at 0x100, SP wraps to FF
        queue_instr(cpu8_pkg::OP_PLA, 8'h80, 3'd0, 1'b0);     // pop wraps SP back to 00
        queue_instr(cpu8_pkg::OP_LDA, 8'hFF, 3'd0, 1'b0);
        queue_instr(cpu8_pkg::OP_LDX, 8'h00, 3'd0, 1'b0);
        queue_instr(cpu8_pkg::OP_LDY, 8'h80, 3'd0, 1'b0);
        queue_instr(cpu8_pkg::OP_ADC, 8'h01, 3'd0, 1'b0);     // carry out, zero
        queue_instr(cpu8_pkg::OP_LDA, 8'h7F, 3'd0, 1'b0);
        queue_instr(cpu8_pkg::OP_ADC, 8'h01, 3'd0, 1'b0);     // signed overflow with carry in
        queue_instr(cpu8_pkg::OP_SBC, 8'hFF, 3'd0, 1'b0);
        queue_instr(cpu8_pkg::OP_CMP, 8'h81, 3'd0, 1'b0);
        queue_instr(cpu8_pkg::OP_CPX, 8'hFF, 3'd0, 1'b0);
        queue_instr(cpu8_pkg::OP_CPY, 8'h80, 3'd0, 1'b0);
        queue_instr(cpu8_pkg::OP_BIT, 8'hC0, 3'd0, 1'b0);
        queue_instr(cpu8_pkg::OP_SED, 8'h00, 3'd0, 1'b0);
        queue_instr(cpu8_pkg::OP_ADC, 8'h99, 3'd0, 1'b0);     // stays binary with D set
        queue_instr(cpu8_pkg::OP_PHP, 8'h00, 3'd0, 1'b0);     // B bits land in P
        queue_instr(cpu8_pkg::OP_CLD, 8'h00, 3'd0, 1'b0);
        queue_instr(cpu8_pkg::OP_PLP, 8'hFF, 3'd0, 1'b0);     // B bits masked off
        queue_instr(cpu8_pkg::OP_DEX, 8'h00, 3'd0, 1'b0);
        queue_instr(cpu8_pkg::OP_TXS, 8'h00, 3'd0, 1'b0);
        queue_instr(cpu8_pkg::OP_TSX, 8'h00, 3'd0, 1'b0);
        queue_instr(cpu8_pkg::OP_BRANCH, 8'h00, 3'd7, 1'b0);
        queue_instr(cpu8_pkg::OP_BRANCH, 8'h00, 3'd0, 1'b0);
        queue_instr(cpu8_pkg::op_t'(6'd63), 8'hFF, 3'd7, 1'b0); // unused code, all ones
        queue_instr(cpu8_pkg::OP_ROR_M, 8'h01, 3'd0, 1'b0);

        // Random: uniform over all operations, operands biased to corners,
        // a sprinkling of unused codes, and a barrier every few hundred items
        n = 0;
        while (n < NUM_RANDOM)
        begin
            if ($urandom_range(0, 99) < 6)
                op = cpu8_pkg::op_t'($urandom_range(cpu8_pkg::OP_PHA + 1, 63));
            else
            begin
                op = cpu8_pkg::op_t'($urandom_range(0, cpu8_pkg::OP_PHA));
                n++;
            end
            case ($urandom_range(0, 9))
                0: m = 8'h00;
                1: m = 8'hFF;
                2: m = 8'h7F;
                3: m = 8'h80;
                4: m = 8'h01;
                default: m = 8'($urandom_range(0, 255));
            endcase
            queue_instr(op, m, 3'($urandom_range(0, 7)), (n % 400 == 1));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (instr_q.size() != 0)
            @(negedge clk);
        @(negedge clk);
        while (!all_retired)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (errors == 0 && retire_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: cpu8_execute_unit.f
hdl/cpu8_pkg.sv
hdl/cpu8_alu.sv
hdl/cpu8_regs.sv
hdl/cpu8_execute_unit.sv
test/cpu8_execute_unit_test.sv
